@@ rtl/xbcf_pkg.sv @@
// ----------------------------------------------------------------------------
// xbcf_pkg
// shared types and constants of the xml block cut finder
// ----------------------------------------------------------------------------
package xbcf_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 17;
   localparam int DEPTH_W = 16;

   // body count saturates here
   localparam logic [COUNT_W-1:0] BLOCK_BYTES = COUNT_W'(65536);

   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7fff;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;
   localparam logic signed [DEPTH_W-1:0] DEPTH_CUT = 16'sd1;

   localparam logic [BYTE_W-1:0] CHAR_LT    = 8'h3c;  // '<'
   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;  // '/'
   localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3e;  // '>'
   localparam logic [BYTE_W-1:0] CHAR_QUEST = 8'h3f;  // '?'

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_LT     = 2'd1,
      PH_SLASH  = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        cut_offset;
      logic                      append_close;
      logic signed [DEPTH_W-1:0] final_depth;
   } result_type;

endpackage

@@ rtl/xml_block_cut_finder.sv @@
// ----------------------------------------------------------------------------
// xml_block_cut_finder
// scans one xml block a byte at a time and reports where to cut it
// ----------------------------------------------------------------------------
//  channel | ports  | word
//  --------+--------+---------------------------------------------------
//  input   | req_*  | data_byte, is_prefix, block_end
//  result  | rsp_*  | cut_offset, append_close, final_depth (on last byte)
//
//  one byte per cycle sustained; the scan state update is combinational logic
//  a result is registered in the output stage as the block's last byte leaves the input stage
//  reset clears both stage valids and the scan state
//  a waiting result stalls input only when the input stage holds a last byte
// ----------------------------------------------------------------------------
module xml_block_cut_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [xbcf_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_is_prefix,
   input  logic                              req_block_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [xbcf_pkg::COUNT_W-1:0]      rsp_cut_offset,
   output logic                              rsp_append_close,
   output logic signed [xbcf_pkg::DEPTH_W-1:0] rsp_final_depth
);
   import xbcf_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_prefix_ff;
   logic              in_end_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        scan_result;
   logic              advance;
   logic              out_free;
   logic              load_out;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_end_ff || out_free);
   assign load_out  = advance && in_end_ff;
   assign req_ready = !in_valid_ff || advance;

   xbcf_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .is_prefix (in_prefix_ff),
      .block_end (in_end_ff),
      .result    (scan_result)
   );

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff   <= req_data_byte;
         in_prefix_ff <= req_is_prefix;
         in_end_ff    <= req_block_end;
      end
      if (load_out) begin
         out_ff <= scan_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cut_offset   = out_ff.cut_offset;
   assign rsp_append_close = out_ff.append_close;
   assign rsp_final_depth  = out_ff.final_depth;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> in_end_ff && out_valid_ff && !rsp_ready)
      else $error("input stage stalled without a waiting result");

   a_append_sign: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.append_close == (out_ff.final_depth > 16'sd0))
      else $error("append flag disagrees with final depth");

endmodule

@@ rtl/xbcf_scan.sv @@
// ----------------------------------------------------------------------------
// xbcf_scan
// per-byte scan state: tag phase, nesting depth, body count and last cut
// ----------------------------------------------------------------------------
module xbcf_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [xbcf_pkg::BYTE_W-1:0] data_byte,
   input  logic                       is_prefix,
   input  logic                       block_end,
   output xbcf_pkg::result_type       result
);
   import xbcf_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic signed [DEPTH_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        cut_ff, cut_in;
   logic                      cut_seen_ff, cut_seen_in;

   logic [COUNT_W-1:0]        count_nx;
   logic signed [DEPTH_W-1:0] depth_up, depth_dn, depth_nx;
   logic [COUNT_W-1:0]        cut_nx;
   logic                      cut_seen_nx;
   phase_type                 phase_nx, phase_plain;
   logic                      is_lt, is_slash, is_gt, is_quest;

   assign is_lt    = (data_byte == CHAR_LT);
   assign is_slash = (data_byte == CHAR_SLASH);
   assign is_gt    = (data_byte == CHAR_GT);
   assign is_quest = (data_byte == CHAR_QUEST);

   assign count_nx = (!is_prefix && count_ff < BLOCK_BYTES) ? count_ff + 1'b1 : count_ff;
   assign depth_up = (depth_ff != DEPTH_MAX) ? depth_ff + 16'sd1 : depth_ff;
   assign depth_dn = (depth_ff != DEPTH_MIN) ? depth_ff - 16'sd1 : depth_ff;

   // phase that a byte leads to when scanned as plain text
   always_comb begin
      if (is_lt) begin
         phase_plain = PH_LT;
      end else if (is_slash) begin
         phase_plain = PH_SLASH;
      end else begin
         phase_plain = PH_NORMAL;
      end
   end

   always_comb begin
      phase_nx    = phase_plain;
      depth_nx    = depth_ff;
      cut_nx      = cut_ff;
      cut_seen_nx = cut_seen_ff;
      case (phase_ff)
         PH_SKIP: begin
            phase_nx = PH_SKIP;
            if (is_gt) begin
               cut_nx      = count_nx;
               cut_seen_nx = 1'b1;
               phase_nx    = PH_NORMAL;
            end
         end
         PH_LT: begin
            if (is_slash) begin
               depth_nx = depth_dn;
               phase_nx = (depth_dn <= DEPTH_CUT) ? PH_SKIP : PH_NORMAL;
            end else if (!is_quest) begin
               depth_nx = depth_up;
            end
         end
         PH_SLASH: begin
            if (is_gt) begin
               depth_nx = depth_dn;
               phase_nx = PH_NORMAL;
               if (depth_dn <= DEPTH_CUT) begin
                  cut_nx      = count_nx;
                  cut_seen_nx = 1'b1;
               end
            end
         end
         default: begin
            phase_nx = phase_plain;
         end
      endcase
   end

   assign result.cut_offset   = cut_seen_nx ? cut_nx : count_nx;
   assign result.append_close = (depth_nx > 16'sd0);
   assign result.final_depth  = depth_nx;

   // last byte of a block returns everything to the start state
   always_comb begin
      phase_in    = phase_ff;
      depth_in    = depth_ff;
      count_in    = count_ff;
      cut_in      = cut_ff;
      cut_seen_in = cut_seen_ff;
      if (step) begin
         if (block_end) begin
            phase_in    = PH_NORMAL;
            depth_in    = '0;
            count_in    = '0;
            cut_in      = '0;
            cut_seen_in = 1'b0;
         end else begin
            phase_in    = phase_nx;
            depth_in    = depth_nx;
            count_in    = count_nx;
            cut_in      = cut_nx;
            cut_seen_in = cut_seen_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NORMAL;
         depth_ff    <= '0;
         count_ff    <= '0;
         cut_ff      <= '0;
         cut_seen_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         depth_ff    <= depth_in;
         count_ff    <= count_in;
         cut_ff      <= cut_in;
         cut_seen_ff <= cut_seen_in;
      end
   end

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      step && block_end |=> phase_ff == PH_NORMAL && depth_ff == 16'sd0 &&
                            count_ff == '0 && !cut_seen_ff)
      else $error("scan state not cleared after block end");

   a_cut_in_body: assert property (@(posedge clock) disable iff (reset)
      cut_seen_ff |-> cut_ff <= count_ff)
      else $error("cut offset beyond body count");

   a_skip_depth: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> depth_ff <= DEPTH_CUT)
      else $error("skipping with depth above one");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BLOCK_BYTES)
      else $error("body count past block size");

endmodule
